// ===== rtl/i2c_master_bit_engine_core_macros.svh =====
// ----------------------------------------------------------------------------
// I2C master bit engine assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_CORE_MACROS_SVH

// same-cycle implication
`define I2CBE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2cbe assertion failed");

// next-cycle implication
`define I2CBE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2cbe assertion failed");

`endif

// ===== rtl/i2cbe_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Phase codes, command codes, engine state and result types.
// ----------------------------------------------------------------------------
package i2cbe_pkg;

  localparam int unsigned CNT_W = 10;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_ST_C    = 5'd3,
    PH_SP_A    = 5'd4,
    PH_SP_B    = 5'd5,
    PH_SP_C    = 5'd6,
    PH_WR_LOW  = 5'd7,
    PH_WR_HIGH = 5'd8,
    PH_WR_TAIL = 5'd9,
    PH_WA_REL  = 5'd10,
    PH_WA_HIGH = 5'd11,
    PH_WA_POLL = 5'd12,
    PH_RD_LOW  = 5'd13,
    PH_RD_HIGH = 5'd14,
    PH_RA_LOW  = 5'd15,
    PH_RA_HIGH = 5'd16
  } phase_t;

  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  localparam logic       CFG_PHASE_TICKS = 1'b0;
  localparam logic       CFG_ACK_TIMEOUT = 1'b1;

  localparam logic [CNT_W-1:0] PHASE_TICKS_RST = 10'd5;
  localparam logic [CNT_W-1:0] ACK_TIMEOUT_RST = 10'd250;
  localparam logic [3:0]       BITS_PER_BYTE   = 4'd8;

  typedef struct packed {
    phase_t           phase;
    logic [3:0]       bit_count;
    logic [7:0]       shift;
    logic [CNT_W-1:0] hold;
    logic [CNT_W-1:0] wait_count;
    logic             ack_choice;
    logic             err;
    logic             scl;
    logic             sda;
    logic [7:0]       received;
  } state_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic       busy;
    logic       done;
    logic [7:0] rx_byte;
    logic       ack_error;
  } result_t;

endpackage

// ===== rtl/i2cbe_step.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine tick step
// Next engine state and line result for one tick item.
// ----------------------------------------------------------------------------
module i2cbe_step (
  input  i2cbe_pkg::state_t                st,
  input  logic [2:0]                       cmd,
  input  logic [7:0]                       tx_byte,
  input  logic                             send_ack,
  input  logic                             sda_in,
  input  logic [i2cbe_pkg::CNT_W-1:0]      phase_ticks,
  input  logic [i2cbe_pkg::CNT_W-1:0]      ack_timeout,
  output i2cbe_pkg::state_t                st_nxt,
  output i2cbe_pkg::result_t               res
);

  logic [i2cbe_pkg::CNT_W-1:0] hold_init;
  logic [3:0]                  bc_inc;
  logic                        done;
  logic                        go_idle;
  i2cbe_pkg::state_t           n;

  function automatic i2cbe_pkg::state_t enter_ph(
    input i2cbe_pkg::state_t              s,
    input i2cbe_pkg::phase_t              nx,
    input logic [i2cbe_pkg::CNT_W-1:0]    hinit,
    input logic                           smp
  );
    i2cbe_pkg::state_t r;
    r       = s;
    r.phase = nx;
    r.hold  = hinit;
    case (nx)
      i2cbe_pkg::PH_ST_A: begin
        r.sda = 1'b1;
        r.scl = 1'b1;
      end
      i2cbe_pkg::PH_ST_B:    r.sda = 1'b0;
      i2cbe_pkg::PH_ST_C:    r.scl = 1'b0;
      i2cbe_pkg::PH_SP_A: begin
        r.scl = 1'b0;
        r.sda = 1'b0;
      end
      i2cbe_pkg::PH_SP_B:    r.scl = 1'b1;
      i2cbe_pkg::PH_SP_C:    r.sda = 1'b1;
      i2cbe_pkg::PH_WR_LOW: begin
        r.scl   = 1'b0;
        r.sda   = s.shift[7];
        r.shift = {s.shift[6:0], 1'b0};
      end
      i2cbe_pkg::PH_WR_HIGH: r.scl = 1'b1;
      i2cbe_pkg::PH_WR_TAIL: r.scl = 1'b0;
      i2cbe_pkg::PH_WA_REL:  r.sda = 1'b1;
      i2cbe_pkg::PH_WA_HIGH: r.scl = 1'b1;
      i2cbe_pkg::PH_RD_LOW: begin
        r.scl = 1'b0;
        r.sda = 1'b1;
      end
      i2cbe_pkg::PH_RD_HIGH: begin
        r.scl   = 1'b1;
        r.shift = {s.shift[6:0], smp};
      end
      i2cbe_pkg::PH_RA_LOW: begin
        r.scl = 1'b0;
        r.sda = ~s.ack_choice;
      end
      i2cbe_pkg::PH_RA_HIGH: r.scl = 1'b1;
      default: ;
    endcase
    return r;
  endfunction

  // zero phase length runs as one
  assign hold_init = (phase_ticks == '0) ? '0 : phase_ticks - 1'b1;
  assign bc_inc    = st.bit_count + 4'd1;

  always_comb begin
    n       = st;
    done    = 1'b0;
    go_idle = 1'b0;
    if (st.phase == i2cbe_pkg::PH_IDLE) begin
      case (cmd)
        i2cbe_pkg::CMD_START: begin
          n.bit_count  = '0;
          n.wait_count = '0;
          n = enter_ph(n, i2cbe_pkg::PH_ST_A, hold_init, sda_in);
        end
        i2cbe_pkg::CMD_STOP: begin
          n.bit_count  = '0;
          n.wait_count = '0;
          n = enter_ph(n, i2cbe_pkg::PH_SP_A, hold_init, sda_in);
        end
        i2cbe_pkg::CMD_WRITE: begin
          n.bit_count  = '0;
          n.wait_count = '0;
          n.shift      = tx_byte;
          n = enter_ph(n, i2cbe_pkg::PH_WR_LOW, hold_init, sda_in);
        end
        i2cbe_pkg::CMD_WAIT: begin
          n.bit_count  = '0;
          n.wait_count = '0;
          n.err        = 1'b0;
          n = enter_ph(n, i2cbe_pkg::PH_WA_REL, hold_init, sda_in);
        end
        i2cbe_pkg::CMD_READ: begin
          n.bit_count  = '0;
          n.wait_count = '0;
          n.ack_choice = send_ack;
          n.shift      = '0;
          n = enter_ph(n, i2cbe_pkg::PH_RD_LOW, hold_init, sda_in);
        end
        default: ;
      endcase
    end else if (st.phase == i2cbe_pkg::PH_WA_POLL) begin
      if (!sda_in) begin
        n.scl   = 1'b0;
        n.phase = i2cbe_pkg::PH_IDLE;
        done    = 1'b1;
      end else if (st.wait_count >= ack_timeout) begin
        n.err = 1'b1;
        n = enter_ph(n, i2cbe_pkg::PH_SP_A, hold_init, sda_in);
      end else begin
        n.wait_count = st.wait_count + 1'b1;
      end
    end else if (st.hold != '0) begin
      n.hold = st.hold - 1'b1;
    end else begin
      case (st.phase)
        i2cbe_pkg::PH_ST_A:    n = enter_ph(n, i2cbe_pkg::PH_ST_B, hold_init, sda_in);
        i2cbe_pkg::PH_ST_B:    n = enter_ph(n, i2cbe_pkg::PH_ST_C, hold_init, sda_in);
        i2cbe_pkg::PH_SP_A:    n = enter_ph(n, i2cbe_pkg::PH_SP_B, hold_init, sda_in);
        i2cbe_pkg::PH_SP_B:    n = enter_ph(n, i2cbe_pkg::PH_SP_C, hold_init, sda_in);
        i2cbe_pkg::PH_WR_LOW:  n = enter_ph(n, i2cbe_pkg::PH_WR_HIGH, hold_init, sda_in);
        i2cbe_pkg::PH_WR_HIGH: n = enter_ph(n, i2cbe_pkg::PH_WR_TAIL, hold_init, sda_in);
        i2cbe_pkg::PH_WR_TAIL: begin
          n.bit_count = bc_inc;
          if (bc_inc < i2cbe_pkg::BITS_PER_BYTE) begin
            n = enter_ph(n, i2cbe_pkg::PH_WR_LOW, hold_init, sda_in);
          end else begin
            go_idle = 1'b1;
          end
        end
        i2cbe_pkg::PH_WA_REL:  n = enter_ph(n, i2cbe_pkg::PH_WA_HIGH, hold_init, sda_in);
        i2cbe_pkg::PH_WA_HIGH: n = enter_ph(n, i2cbe_pkg::PH_WA_POLL, hold_init, sda_in);
        i2cbe_pkg::PH_RD_LOW:  n = enter_ph(n, i2cbe_pkg::PH_RD_HIGH, hold_init, sda_in);
        i2cbe_pkg::PH_RD_HIGH: begin
          n.bit_count = bc_inc;
          if (bc_inc < i2cbe_pkg::BITS_PER_BYTE) begin
            n = enter_ph(n, i2cbe_pkg::PH_RD_LOW, hold_init, sda_in);
          end else begin
            n.received = st.shift;
            n = enter_ph(n, i2cbe_pkg::PH_RA_LOW, hold_init, sda_in);
          end
        end
        i2cbe_pkg::PH_RA_LOW:  n = enter_ph(n, i2cbe_pkg::PH_RA_HIGH, hold_init, sda_in);
        i2cbe_pkg::PH_RA_HIGH: begin
          n.scl   = 1'b0;
          go_idle = 1'b1;
        end
        default: go_idle = 1'b1;
      endcase
      if (go_idle) begin
        n.phase = i2cbe_pkg::PH_IDLE;
        n.hold  = '0;
        done    = 1'b1;
      end
    end
  end

  assign st_nxt          = n;
  assign res.scl_level   = n.scl;
  assign res.sda_release = n.sda;
  assign res.busy        = (n.phase != i2cbe_pkg::PH_IDLE);
  assign res.done        = done;
  assign res.rx_byte     = n.received;
  assign res.ack_error   = n.err;

endmodule

// ===== rtl/i2c_master_bit_engine_core.sv =====
// ----------------------------------------------------------------------------
// I2C master bit engine core
// A tick item is registered at input, then its result in the result register.
// Throughput: one tick item per cycle unless the result register is stalled.
// A stalled result register holds the input register and then in_ready.
// Reset (synchronous, active low): idle, lines released, config to defaults.
// ----------------------------------------------------------------------------
`include "i2c_master_bit_engine_core_macros.svh"

module i2c_master_bit_engine_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_cmd,
  input  logic [7:0] in_tx_byte,
  input  logic       in_send_ack,
  input  logic       in_sda_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_scl_level,
  output logic       out_sda_release,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [7:0] out_rx_byte,
  output logic       out_ack_error,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [9:0] cfg_wdata
);

  logic                        s1_valid_r;
  logic [2:0]                  s1_cmd_r;
  logic [7:0]                  s1_tx_r;
  logic                        s1_ack_r;
  logic                        s1_sda_r;
  logic                        s1_move;
  logic [i2cbe_pkg::CNT_W-1:0] phase_ticks_r;
  logic [i2cbe_pkg::CNT_W-1:0] ack_timeout_r;
  i2cbe_pkg::state_t           st_r;
  i2cbe_pkg::state_t           st_nxt;
  i2cbe_pkg::result_t          res_nxt;
  logic                        out_valid_r;
  i2cbe_pkg::result_t          out_r;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_ticks_r <= i2cbe_pkg::PHASE_TICKS_RST;
      ack_timeout_r <= i2cbe_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cbe_pkg::CFG_PHASE_TICKS: phase_ticks_r <= cfg_wdata;
        i2cbe_pkg::CFG_ACK_TIMEOUT: ack_timeout_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_cmd_r <= in_cmd;
      s1_tx_r  <= in_tx_byte;
      s1_ack_r <= in_send_ack;
      s1_sda_r <= in_sda_in;
    end
  end

  i2cbe_step u_step (
    .st          (st_r),
    .cmd         (s1_cmd_r),
    .tx_byte     (s1_tx_r),
    .send_ack    (s1_ack_r),
    .sda_in      (s1_sda_r),
    .phase_ticks (phase_ticks_r),
    .ack_timeout (ack_timeout_r),
    .st_nxt      (st_nxt),
    .res         (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= i2cbe_pkg::PH_IDLE;
      st_r.bit_count  <= '0;
      st_r.shift      <= '0;
      st_r.hold       <= '0;
      st_r.wait_count <= '0;
      st_r.ack_choice <= 1'b0;
      st_r.err        <= 1'b0;
      st_r.scl        <= 1'b1;
      st_r.sda        <= 1'b1;
      st_r.received   <= '0;
    end else if (s1_move) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_scl_level   = out_r.scl_level;
  assign out_sda_release = out_r.sda_release;
  assign out_busy_res    = out_r.busy;
  assign out_done_res    = out_r.done;
  assign out_rx_byte     = out_r.rx_byte;
  assign out_ack_error   = out_r.ack_error;

  `I2CBE_ASSERT_NEXT(a_move_fills_out, clk, rst_n, s1_move, out_valid_r)
  `I2CBE_ASSERT_NEXT(a_s1_holds, clk, rst_n, s1_valid_r && !s1_move, s1_valid_r)
  `I2CBE_ASSERT_SAME(a_done_not_busy, clk, rst_n, out_valid_r && out_r.done, !out_r.busy)
  `I2CBE_ASSERT_SAME(a_bit_count_range, clk, rst_n, 1'b1,
    st_r.bit_count <= i2cbe_pkg::BITS_PER_BYTE)

endmodule
